// File: rtl/fsf_pkg.sv
// Shared types, constants and the byte-stuffing function of the info frame framer.
// No dependencies; every other file of the block uses it.
package fsf_pkg;

    localparam int unsigned MaxRun = 9;   // longest burst of line bytes for one payload byte
    localparam int unsigned RunCntW = 4;  // holds 0..MaxRun
    localparam int unsigned HdrLen = 4;   // flag, address, control, header check

    typedef enum logic [2:0] {
        REG_FLAG       = 3'd0,
        REG_ESCAPE     = 3'd1,
        REG_FLAG_SUB   = 3'd2,
        REG_ESCAPE_SUB = 3'd3,
        REG_ADDRESS    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] escape_byte;
        logic [7:0] flag_substitute;
        logic [7:0] escape_substitute;
        logic [7:0] address_byte;
    } cfg_t;

    // One burst of line bytes caused by a single payload byte.
    typedef struct packed {
        logic [MaxRun-1:0][7:0] line;
        logic [RunCntW-1:0]     count;
        logic                   closes;
    } burst_t;

    typedef struct packed {
        logic       esc;
        logic [7:0] b0;
        logic [7:0] b1;
    } stuffed_t;

    // The flag rule wins when flag and escape share a value.
    function automatic stuffed_t stuff(input logic [7:0] b, input cfg_t cfg);
        stuffed_t s;
        s.esc = 1'b0;
        s.b0  = b;
        s.b1  = cfg.escape_substitute;
        if (b == cfg.flag_byte) begin
            s.esc = 1'b1;
            s.b0  = cfg.escape_byte;
            s.b1  = cfg.flag_substitute;
        end else if (b == cfg.escape_byte) begin
            s.esc = 1'b1;
            s.b0  = cfg.escape_byte;
            s.b1  = cfg.escape_substitute;
        end
        return s;
    endfunction

endpackage

// File: rtl/fsf_cfg_regs.sv
// Configuration register file of the info frame framer.
// Depends on fsf_pkg for the register indexes and the cfg_t bundle.
module fsf_cfg_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_addr,
    input  logic [7:0]         cfg_wr_data,
    output fsf_pkg::cfg_t      cfg
);

    fsf_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flag_byte         <= 8'd126;
            cfg_reg.escape_byte       <= 8'd125;
            cfg_reg.flag_substitute   <= 8'd94;
            cfg_reg.escape_substitute <= 8'd93;
            cfg_reg.address_byte      <= 8'd3;
        end else if (cfg_wr_en) begin
            case (fsf_pkg::cfg_index_t'(cfg_addr))
                fsf_pkg::REG_FLAG:       cfg_reg.flag_byte         <= cfg_wr_data;
                fsf_pkg::REG_ESCAPE:     cfg_reg.escape_byte       <= cfg_wr_data;
                fsf_pkg::REG_FLAG_SUB:   cfg_reg.flag_substitute   <= cfg_wr_data;
                fsf_pkg::REG_ESCAPE_SUB: cfg_reg.escape_substitute <= cfg_wr_data;
                fsf_pkg::REG_ADDRESS:    cfg_reg.address_byte      <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/fsf_builder.sv
// Frame state and burst builder: turns one payload byte into its burst of line bytes.
// Depends on fsf_pkg; feeds fsf_serializer through a one-entry burst register.
module fsf_builder (
    input  logic              aclk,
    input  logic              aresetn,
    input  fsf_pkg::cfg_t     cfg,
    input  logic              in_fire,
    input  logic [7:0]        payload_byte,
    input  logic              first_of_frame,
    input  logic              last_of_frame,
    input  logic [7:0]        control_byte,
    input  logic              burst_take,
    output logic              burst_valid,
    output fsf_pkg::burst_t   burst
);

    logic [7:0]        check_reg, check_next;
    logic              in_frame_reg, in_frame_next;
    logic              pend_valid_reg, pend_valid_next;
    fsf_pkg::burst_t   pend_reg, pend_next;
    fsf_pkg::burst_t   run;
    fsf_pkg::stuffed_t st_data, st_check;
    logic [fsf_pkg::RunCntW-1:0] n;
    logic              active;
    logic [7:0]        new_check;

    assign active    = first_of_frame || in_frame_reg;
    assign new_check = (first_of_frame ? 8'd0 : check_reg) ^ payload_byte;
    assign st_data   = fsf_pkg::stuff(payload_byte, cfg);
    assign st_check  = fsf_pkg::stuff(new_check, cfg);

    // Positions shift with the header and with each escaped byte.
    always_comb begin
        run = '0;
        n   = '0;
        if (first_of_frame) begin
            run.line[0] = cfg.flag_byte;
            run.line[1] = cfg.address_byte;
            run.line[2] = control_byte;
            run.line[3] = cfg.address_byte ^ control_byte;
            n = fsf_pkg::RunCntW'(fsf_pkg::HdrLen);
        end
        run.line[n] = st_data.b0;
        n = n + 1'b1;
        if (st_data.esc) begin
            run.line[n] = st_data.b1;
            n = n + 1'b1;
        end
        if (last_of_frame) begin
            run.line[n] = st_check.b0;
            n = n + 1'b1;
            if (st_check.esc) begin
                run.line[n] = st_check.b1;
                n = n + 1'b1;
            end
            run.line[n] = cfg.flag_byte;
            n = n + 1'b1;
        end
        run.count  = n;
        run.closes = last_of_frame;
    end

    always_comb begin
        check_next      = check_reg;
        in_frame_next   = in_frame_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg && !burst_take;
        if (in_fire && active) begin
            check_next      = new_check;
            in_frame_next   = !last_of_frame;
            pend_next       = run;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_reg      <= 8'd0;
            in_frame_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            check_reg      <= check_next;
            in_frame_reg   <= in_frame_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
    end

    assign burst_valid = pend_valid_reg;
    assign burst       = pend_reg;

endmodule

// File: rtl/fsf_serializer.sv
// Output serializer: sends a burst one line byte per transaction.
// Depends on fsf_pkg for the burst_t type.
module fsf_serializer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              burst_valid,
    input  fsf_pkg::burst_t   burst,
    output logic              burst_take,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        line_byte,
    output logic              run_end,
    output logic              frame_end
);

    fsf_pkg::burst_t              cur_reg, cur_next;
    logic                         cur_valid_reg, cur_valid_next;
    logic [fsf_pkg::RunCntW-1:0]  idx_reg, idx_next;
    logic                         is_last;
    logic                         fire;

    assign is_last    = (idx_reg == cur_reg.count - 1'b1);
    assign fire       = cur_valid_reg && out_ready;
    // A waiting burst moves in when the slot is empty or its final byte leaves now.
    assign burst_take = burst_valid && (!cur_valid_reg || (fire && is_last));

    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (fire) begin
            if (is_last) begin
                cur_valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
        if (burst_take) begin
            cur_next       = burst;
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    assign out_valid = cur_valid_reg;
    assign line_byte = cur_reg.line[idx_reg];
    assign run_end   = is_last;
    assign frame_end = is_last && cur_reg.closes;

endmodule

// File: rtl/info_frame_stuffing_framer.sv
// Top level of the info frame framer: config registers, burst builder and serializer.
// Depends on fsf_pkg, fsf_cfg_regs, fsf_builder and fsf_serializer.
//
// Each accepted payload byte yields a burst of one to nine line bytes: one or two for a
// plain or escaped byte in mid-frame, up to nine when it opens and closes a frame at
// once. The line bytes are sent one per cycle on the m_ side while m_tready is high;
// the output serializer sets that rate. One burst waits in a holding register, so a
// new payload byte is taken while the previous burst is still being sent. A byte that
// is neither first of a frame nor inside an open frame is accepted and dropped. An
// accepted byte passes through the holding register and then the serializer's burst
// register before its first line byte leaves.
module info_frame_stuffing_framer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] payload_byte, [15:8] control_byte
    input  logic        s_tlast,   // last_of_frame
    input  logic        s_tuser,   // first_of_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] line_byte
    output logic        m_tlast,   // run_end
    output logic        m_tuser,   // frame_end
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [7:0]  cfg_wr_data
);

    fsf_pkg::cfg_t   cfg;
    fsf_pkg::burst_t burst;
    logic            burst_valid;
    logic            burst_take;
    logic            in_fire;

    assign s_tready = !burst_valid || burst_take;
    assign in_fire  = s_tvalid && s_tready;

    fsf_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    fsf_builder u_build (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .in_fire        (in_fire),
        .payload_byte   (s_tdata[7:0]),
        .first_of_frame (s_tuser),
        .last_of_frame  (s_tlast),
        .control_byte   (s_tdata[15:8]),
        .burst_take     (burst_take),
        .burst_valid    (burst_valid),
        .burst          (burst)
    );

    fsf_serializer u_ser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .burst_valid (burst_valid),
        .burst       (burst),
        .burst_take  (burst_take),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .line_byte   (m_tdata),
        .run_end     (m_tlast),
        .frame_end   (m_tuser)
    );

    // The closing flag is always the final byte of its burst.
    a_frame_end_is_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tuser |-> m_tlast)
        else $error("frame_end raised on a byte that does not end its burst");

    // A held burst that is not taken stays pending.
    a_burst_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (burst_valid && !burst_take) |=> burst_valid)
        else $error("pending burst lost before the serializer took it");

    // A stalled output byte does not change.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output byte changed while stalled");

    // Nothing is offered in the cycle after reset.
    a_idle_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

// File: tb/tb_info_frame_stuffing_framer.sv
// Self-checking testbench for info_frame_stuffing_framer: frame headers, byte stuffing, XOR check.
// Holds its own frame predictor and a scoreboard of expected line bytes; needs fsf_pkg and the RTL.
`timescale 1ns / 100ps

module tb_info_frame_stuffing_framer;

    localparam int CycleLimit = 300000;
    localparam int SettleCycles = 12;
    localparam int RandomItemsPerPhase = 75;
    localparam logic [2:0] RegSpareLo = 3'd5;
    localparam logic [2:0] RegSpareHi = 3'd7;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       run_end;
        logic       frame_end;
    } line_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // [7:0] payload_byte, [15:8] control_byte
    logic        s_tlast = 1'b0; // last_of_frame
    logic        s_tuser = 1'b0; // first_of_frame
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // [7:0] line_byte
    logic        m_tlast;        // run_end
    logic        m_tuser;        // frame_end
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [7:0]  cfg_wr_data = '0;

    // Local copy of the register file and the frame state.
    logic [7:0] flag_val = 8'd126;
    logic [7:0] esc_val = 8'd125;
    logic [7:0] flag_sub_val = 8'd94;
    logic [7:0] esc_sub_val = 8'd93;
    logic [7:0] addr_val = 8'd3;
    logic [7:0] payload_xor = '0;
    logic       frame_open = 1'b0;

    logic [7:0] burst_bytes [0:fsf_pkg::MaxRun-1];
    logic       burst_closes [0:fsf_pkg::MaxRun-1];
    int         burst_len;

    line_out_t  expected_line_q[$];
    int         mismatch_count = 0;
    int         productive_items = 0;
    int         cycle_count = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;

    info_frame_stuffing_framer dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("%0t: timeout with %0d line bytes outstanding", $time,
                     expected_line_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : check_line_bytes
        line_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_line_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected line byte: expected none, actual %02h", $time,
                         m_tdata);
            end else begin
                want = expected_line_q.pop_front();
                if (m_tdata !== want.line_byte) begin
                    mismatch_count++;
                    $display("%0t: line_byte mismatch: expected %02h, actual %02h", $time,
                             want.line_byte, m_tdata);
                end
                if (m_tlast !== want.run_end) begin
                    mismatch_count++;
                    $display("%0t: run_end mismatch: expected %0b, actual %0b", $time,
                             want.run_end, m_tlast);
                end
                if (m_tuser !== want.frame_end) begin
                    mismatch_count++;
                    $display("%0t: frame_end mismatch: expected %0b, actual %0b", $time,
                             want.frame_end, m_tuser);
                end
            end
        end
    end

    function automatic void add_line_byte(input logic [7:0] b, input logic closes);
        burst_bytes[burst_len] = b;
        burst_closes[burst_len] = closes;
        burst_len++;
    endfunction

    // A byte matching the flag is escaped as a flag even when it also matches the escape.
    function automatic void add_stuffed_byte(input logic [7:0] b);
        if (b == flag_val) begin
            add_line_byte(esc_val, 1'b0);
            add_line_byte(flag_sub_val, 1'b0);
        end else if (b == esc_val) begin
            add_line_byte(esc_val, 1'b0);
            add_line_byte(esc_sub_val, 1'b0);
        end else begin
            add_line_byte(b, 1'b0);
        end
    endfunction

    function automatic int predict_line_bytes(input logic [7:0] data, input logic first,
                                              input logic last, input logic [7:0] ctrl);
        line_out_t item;
        burst_len = 0;
        if (first) begin
            add_line_byte(flag_val, 1'b0);
            add_line_byte(addr_val, 1'b0);
            add_line_byte(ctrl, 1'b0);
            add_line_byte(addr_val ^ ctrl, 1'b0);
            payload_xor = '0;
            frame_open = 1'b1;
        end else if (!frame_open) begin
            return 0;
        end
        add_stuffed_byte(data);
        payload_xor = payload_xor ^ data;
        if (last) begin
            add_stuffed_byte(payload_xor);
            add_line_byte(flag_val, 1'b1);
            frame_open = 1'b0;
        end
        for (int i = 0; i < burst_len; i++) begin
            item.line_byte = burst_bytes[i];
            item.run_end = (i == burst_len - 1);
            item.frame_end = burst_closes[i];
            expected_line_q.push_back(item);
        end
        return burst_len;
    endfunction

    // Starts and ends just after a falling edge; tvalid stays high unless a gap is drawn.
    task automatic send_payload(input logic [7:0] data, input logic first, input logic last,
                                input logic [7:0] ctrl);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata = {ctrl, data};
        s_tuser = first;
        s_tlast = last;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (predict_line_bytes(data, first, last, ctrl) > 0) productive_items++;
        @(negedge aclk);
    endtask

    // Dropped bytes never show up on the output, so allow them time to pass through.
    task automatic wait_drain();
        s_tvalid = 1'b0;
        while (expected_line_q.size() != 0) @(negedge aclk);
        repeat (SettleCycles) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
        wait_drain();
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            fsf_pkg::REG_FLAG:       flag_val = value;
            fsf_pkg::REG_ESCAPE:     esc_val = value;
            fsf_pkg::REG_FLAG_SUB:   flag_sub_val = value;
            fsf_pkg::REG_ESCAPE_SUB: esc_sub_val = value;
            fsf_pkg::REG_ADDRESS:    addr_val = value;
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [7:0] flag_b, input logic [7:0] esc_b,
                                  input logic [7:0] flag_sub_b, input logic [7:0] esc_sub_b,
                                  input logic [7:0] addr_b);
        write_reg(fsf_pkg::REG_FLAG, flag_b);
        write_reg(fsf_pkg::REG_ESCAPE, esc_b);
        write_reg(fsf_pkg::REG_FLAG_SUB, flag_sub_b);
        write_reg(fsf_pkg::REG_ESCAPE_SUB, esc_sub_b);
        write_reg(fsf_pkg::REG_ADDRESS, addr_b);
    endtask

    function automatic logic [7:0] pick_payload();
        int r;
        r = $urandom_range(99);
        if (r < 20) return flag_val;
        if (r < 35) return esc_val;
        return 8'($urandom);
    endfunction

    task automatic test_default_frames();
        // Single-byte frame whose payload and check both need the flag escape.
        send_payload(8'h7E, 1'b1, 1'b1, 8'hFF);
        send_payload(8'h7D, 1'b1, 1'b0, 8'h00);
        send_payload(8'h00, 1'b0, 1'b0, 8'hA5);
        send_payload(8'hFF, 1'b0, 1'b0, 8'h00);
        send_payload(8'h55, 1'b0, 1'b1, 8'h00);
        // No frame is open, so these bytes are dropped.
        send_payload(8'h7E, 1'b0, 1'b0, 8'h3C);
        send_payload(8'h12, 1'b0, 1'b1, 8'hC3);
        // Restart abandons the open frame; the new frame's check lands on the flag value.
        send_payload(8'h01, 1'b1, 1'b0, 8'h11);
        send_payload(8'h02, 1'b1, 1'b0, 8'h22);
        send_payload(8'h7C, 1'b0, 1'b0, 8'h00);
        send_payload(8'h00, 1'b0, 1'b1, 8'h00);
        // Header bytes matching the escape go out unstuffed; the check is escaped.
        send_payload(8'h7D, 1'b1, 1'b1, 8'h7D);
    endtask

    task automatic test_config_extremes();
        write_all_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_payload(8'h00, 1'b1, 1'b1, 8'h00);
        write_all_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_payload(8'hFF, 1'b1, 1'b0, 8'hFF);
        send_payload(8'h00, 1'b0, 1'b1, 8'h80);
        write_all_regs(8'h00, 8'hFF, 8'h80, 8'h01, 8'hFF);
        send_payload(8'h00, 1'b1, 1'b0, 8'h00);
        send_payload(8'hFF, 1'b0, 1'b1, 8'h7F);
    endtask

    task automatic test_flag_equals_escape();
        write_all_regs(8'hAA, 8'hAA, 8'h55, 8'h33, 8'h96);
        send_payload(8'hAA, 1'b1, 1'b1, 8'hC3);
    endtask

    task automatic test_unused_index();
        for (int i = RegSpareLo; i <= RegSpareHi; i++) begin
            write_reg(3'(i), 8'($urandom));
        end
        send_payload(8'hAA, 1'b1, 1'b0, 8'h01);
        send_payload(8'h33, 1'b0, 1'b1, 8'h02);
    endtask

    task automatic test_random_frames();
        int send_pcts [4];
        int recv_pcts [4];
        int start_count;
        int frame_len;
        int kind;
        logic [7:0] shared;
        logic drained;
        send_pcts = '{0, 67, 0, 23};
        recv_pcts = '{0, 0, 67, 23};
        for (int p = 0; p < 4; p++) begin
            shared = 8'($urandom);
            // A quarter of the settings let the flag and escape share one value.
            write_all_regs(shared, ($urandom_range(3) == 0) ? shared : 8'($urandom),
                           8'($urandom), 8'($urandom), 8'($urandom));
            send_idle_pct = send_pcts[p];
            recv_stall_pct = recv_pcts[p];
            start_count = productive_items;
            drained = 1'b0;
            while (productive_items - start_count < RandomItemsPerPhase) begin
                kind = $urandom_range(99);
                frame_len = ($urandom_range(9) == 0) ? $urandom_range(9, 16)
                                                     : $urandom_range(1, 5);
                if (kind < 8) begin
                    send_payload(pick_payload(), 1'b0, 1'($urandom), 8'($urandom));
                end else begin
                    // Broken frames leave out their last byte and get restarted.
                    for (int i = 0; i < frame_len; i++) begin
                        send_payload(pick_payload(), i == 0,
                                     (kind >= 20) && (i == frame_len - 1), 8'($urandom));
                    end
                end
                if (p == 1 && !drained &&
                    productive_items - start_count >= RandomItemsPerPhase / 2) begin
                    wait_drain();
                    drained = 1'b1;
                end
            end
        end
    endtask

    initial begin
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_default_frames();
        test_config_extremes();
        test_flag_equals_escape();
        test_unused_index();
        test_random_frames();
        wait_drain();
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
